/* sv/bdht_pkg.sv */
// shared types, constants and helpers for the button debounce hold timer
package bdht_pkg;

	localparam int AGE_W = 16;
	localparam int DEB_W = 10;
	localparam int IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	localparam logic [DEB_W-1:0] DEBOUNCE_RST = 10'd30;
	localparam logic [AGE_W-1:0] LONG_HOLD_RST = 16'd10000;
	localparam logic [AGE_W-1:0] HEARTBEAT_RST = 16'd1000;

	localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [IDX_W-1:0] REG_LONG_HOLD = 2'd1;
	localparam logic [IDX_W-1:0] REG_HEARTBEAT = 2'd2;

	localparam logic [1:0] EDGE_NONE = 2'd0;
	localparam logic [1:0] EDGE_PRESS = 2'd1;
	localparam logic [1:0] EDGE_RELEASE = 2'd2;

	typedef struct packed {
		logic [DEB_W-1:0] debounce_ticks;
		logic [AGE_W-1:0] long_hold_ticks;
		logic [AGE_W-1:0] heartbeat_ticks;
	} cfg_t;

	typedef struct packed {
		logic pressed;
		logic [1:0] edge_event;
		logic long_hold_event;
		logic long_pressed;
		logic heartbeat_event;
		logic [AGE_W-1:0] hold_report;
	} res_t;

	function automatic logic [AGE_W-1:0] age_step(input logic [AGE_W-1:0] a);
		age_step = (a == AGE_MAX) ? AGE_MAX : a + 16'd1;
	endfunction

endpackage

/* sv/bdht_cfg.sv */
// configuration register file for the button debounce hold timer
module bdht_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [bdht_pkg::IDX_W-1:0] cfg_index,
	input logic [bdht_pkg::CFG_DATA_W-1:0] cfg_data,
	output bdht_pkg::cfg_t cfg
);
	import bdht_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DEBOUNCE_RST;
			cfg_q.long_hold_ticks <= LONG_HOLD_RST;
			cfg_q.heartbeat_ticks <= HEARTBEAT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data[DEB_W-1:0];
				REG_LONG_HOLD: cfg_q.long_hold_ticks <= cfg_data;
				REG_HEARTBEAT: cfg_q.heartbeat_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* sv/bdht_core.sv */
// debounce, hold timer, long-hold and heartbeat state with its per-tick update
module bdht_core (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic raw,
	input bdht_pkg::cfg_t cfg,
	output bdht_pkg::res_t res
);
	import bdht_pkg::*;

	logic last_raw_q;
	logic stable_q;
	logic [AGE_W-1:0] raw_age_q;
	logic [AGE_W-1:0] press_age_q;
	logic [AGE_W-1:0] last_hold_q;
	logic long_done_q;
	logic [AGE_W-1:0] hb_age_q;

	logic [AGE_W-1:0] raw_age_n;
	logic [AGE_W-1:0] press_age_n;
	logic [AGE_W-1:0] last_hold_n;
	logic [AGE_W-1:0] hb_age_n;
	logic stable_n;
	logic long_done_n;
	logic take;
	logic lh_fire;
	logic hb_fire;
	logic [1:0] edge_n;

	always_comb begin
		raw_age_n = age_step(raw_age_q);
		press_age_n = age_step(press_age_q);
		hb_age_n = age_step(hb_age_q);
		last_hold_n = last_hold_q;
		stable_n = stable_q;
		long_done_n = long_done_q;
		edge_n = EDGE_NONE;

		if (raw != last_raw_q) begin
			raw_age_n = '0;
		end

		take = (raw != stable_q) && (raw_age_n >= {{(AGE_W-DEB_W){1'b0}}, cfg.debounce_ticks});
		if (take) begin
			stable_n = raw;
			if (raw) begin
				press_age_n = '0;
				last_hold_n = '0;
				long_done_n = 1'b0;
				edge_n = EDGE_PRESS;
			end else begin
				last_hold_n = press_age_n;
				edge_n = EDGE_RELEASE;
			end
		end

		lh_fire = stable_n && !long_done_n && (press_age_n >= cfg.long_hold_ticks);
		if (lh_fire) begin
			long_done_n = 1'b1;
		end

		hb_fire = (hb_age_n >= cfg.heartbeat_ticks);
		if (hb_fire) begin
			hb_age_n = '0;
		end

		res.pressed = stable_n;
		res.edge_event = edge_n;
		res.long_hold_event = lh_fire;
		res.long_pressed = stable_n && (press_age_n >= cfg.long_hold_ticks);
		res.heartbeat_event = hb_fire;
		res.hold_report = stable_n ? press_age_n : last_hold_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q <= 1'b0;
			stable_q <= 1'b0;
			raw_age_q <= '0;
			press_age_q <= '0;
			last_hold_q <= '0;
			long_done_q <= 1'b0;
			hb_age_q <= '0;
		end else if (step) begin
			last_raw_q <= raw;
			stable_q <= stable_n;
			raw_age_q <= raw_age_n;
			press_age_q <= press_age_n;
			last_hold_q <= last_hold_n;
			long_done_q <= long_done_n;
			hb_age_q <= hb_age_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		step && long_done_q && stable_q |-> !res.long_hold_event)
		else $error("second long-hold pulse in one press");

endmodule

/* sv/button_debounce_hold_timer.sv */
// top level of the button debounce hold timer with input and result registers
//
// channel | signals                                   | accept
// in      | in_valid, in_stall, raw_level             | in_valid & !in_stall
// out     | out_valid, out_stall, pressed ... hold    | out_valid & !out_stall
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// one request per cycle sustained while out_stall is low; input passes the input register, then the result register
// the state update is combinational between the input and result registers
// reset clears the valid bits of both registers and the state, and loads the default configuration
// a held result stalls the input register, which then stalls the input side
module button_debounce_hold_timer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic raw_level,
	output logic out_valid,
	input logic out_stall,
	output logic pressed,
	output logic [1:0] edge_event,
	output logic long_hold_event,
	output logic long_pressed,
	output logic heartbeat_event,
	output logic [bdht_pkg::AGE_W-1:0] hold_report,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [bdht_pkg::IDX_W-1:0] cfg_index,
	input logic [bdht_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bdht_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t res_s2;
	logic valid_s1;
	logic raw_s1;
	logic valid_s2;
	logic adv_s2;
	logic move;

	bdht_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	bdht_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(move),
		.raw(raw_s1),
		.cfg(cfg),
		.res(res)
	);

	assign adv_s2 = !valid_s2 || !out_stall;
	assign move = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= move;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			raw_s1 <= raw_level;
		end
		if (move) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign pressed = res_s2.pressed;
	assign edge_event = res_s2.edge_event;
	assign long_hold_event = res_s2.long_hold_event;
	assign long_pressed = res_s2.long_pressed;
	assign heartbeat_event = res_s2.heartbeat_event;
	assign hold_report = res_s2.hold_report;

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s2 && out_stall)
		else $error("input stalled while result register free");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && edge_event == EDGE_PRESS |-> pressed && hold_report == '0)
		else $error("press result not pressed or nonzero hold");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && edge_event == EDGE_RELEASE |-> !pressed && !long_pressed)
		else $error("release result still pressed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && long_hold_event |-> long_pressed)
		else $error("long-hold pulse without long press");

	assert property (@(posedge clk) disable iff (!arst_n)
		move |=> valid_s2)
		else $error("advanced request lost before result register");

endmodule
